// ----- sv/ple_pkg.sv -----
package ple_pkg;

    localparam int LIST_CAP_DEF = 16;

    localparam logic [2:0] ACT_INS_FRONT = 3'd0;
    localparam logic [2:0] ACT_APPEND    = 3'd1;
    localparam logic [2:0] ACT_INS_POS   = 3'd2;
    localparam logic [2:0] ACT_DEL_POS   = 3'd3;
    localparam logic [2:0] ACT_TRAVERSE  = 3'd4;
    localparam logic [2:0] ACT_CLEAR     = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]         action;
        logic [6:0]         position;
        logic signed [31:0] value;
    } item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] elem_value;
        logic [5:0]         elem_index;
        logic [6:0]         count;
        logic               last;
    } result_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_TRAV
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic trav_step;
    } dp_cmd_t;

    typedef struct packed {
        logic is_trav;
        logic empty;
        logic trav_last;
    } dp_stat_t;

endpackage

// ----- sv/ple_ctrl.sv -----
module ple_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  ple_pkg::dp_stat_t stat,
    output ple_pkg::dp_cmd_t  cmd,
    output logic              busy
);
    import ple_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (stat.is_trav && !stat.empty && !stat.trav_last)
                begin
                    state_next = S_TRAV;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_TRAV:
            begin
                if (stat.trav_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            S_EXEC:
            begin
                if (stat.is_trav && !stat.empty)
                begin
                    cmd.trav_step = 1'b1;
                end
                else
                begin
                    cmd.exec = 1'b1;
                end
            end
            S_TRAV:
            begin
                cmd.trav_step = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

endmodule

// ----- sv/ple_dpath.sv -----
module ple_dpath #(
    parameter int LIST_CAP = ple_pkg::LIST_CAP_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  ple_pkg::item_t    item,
    input  ple_pkg::dp_cmd_t  cmd,
    output ple_pkg::dp_stat_t stat,
    output ple_pkg::result_t  result,
    output logic              result_valid
);
    import ple_pkg::*;

    localparam int CW = $clog2(LIST_CAP + 1);
    localparam int IW = $clog2(LIST_CAP);

    item_t              item_reg;
    logic signed [31:0] cells_reg [LIST_CAP];
    logic signed [31:0] cells_next [LIST_CAP];
    logic signed [31:0] up [LIST_CAP];
    logic signed [31:0] dn [LIST_CAP];
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic [IW-1:0]      trav_idx_reg;
    logic [IW-1:0]      trav_idx_next;
    result_t            result_reg;
    result_t            result_next;
    logic               valid_reg;
    logic [6:0]         idx;
    logic [6:0]         tgt;
    logic [6:0]         cnt7;
    logic [1:0]         st;

    assign cnt7 = 7'(count_reg);
    assign idx  = (item_reg.position == 7'd0) ? 7'd0 : item_reg.position - 7'd1;

    always_comb
    begin
        case (item_reg.action)
            ACT_INS_FRONT: tgt = 7'd0;
            ACT_APPEND:    tgt = cnt7;
            default:       tgt = idx;
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < LIST_CAP; i++)
        begin
            up[i] = cells_reg[(i + 1) % LIST_CAP];
            dn[i] = cells_reg[(i + LIST_CAP - 1) % LIST_CAP];
        end
    end

    assign stat.is_trav   = (item_reg.action == ACT_TRAVERSE);
    assign stat.empty     = (count_reg == '0);
    assign stat.trav_last = (CW'(trav_idx_reg) == count_reg - CW'(1));

    always_comb
    begin
        cells_next    = cells_reg;
        count_next    = count_reg;
        trav_idx_next = trav_idx_reg;
        result_next   = result_reg;
        st            = ST_OK;

        if (cmd.load)
        begin
            trav_idx_next = '0;
        end

        if (cmd.exec)
        begin
            case (item_reg.action)
                ACT_INS_FRONT, ACT_APPEND, ACT_INS_POS:
                begin
                    if (tgt > cnt7)
                    begin
                        st = ST_RANGE;
                    end
                    else if (count_reg >= CW'(LIST_CAP))
                    begin
                        st = ST_FULL;
                    end
                    else
                    begin
                        for (int i = 0; i < LIST_CAP; i++)
                        begin
                            if (7'(i) > tgt)
                            begin
                                cells_next[i] = dn[i];
                            end
                            else if (7'(i) == tgt)
                            begin
                                cells_next[i] = item_reg.value;
                            end
                        end
                        count_next = count_reg + CW'(1);
                    end
                end
                ACT_DEL_POS:
                begin
                    if (idx >= cnt7)
                    begin
                        st = ST_RANGE;
                    end
                    else
                    begin
                        for (int i = 0; i < LIST_CAP - 1; i++)
                        begin
                            if (7'(i) >= idx)
                            begin
                                cells_next[i] = up[i];
                            end
                        end
                        count_next = count_reg - CW'(1);
                    end
                end
                ACT_TRAVERSE:
                begin
                    st = ST_RANGE;
                end
                ACT_CLEAR:
                begin
                    count_next = '0;
                end
                default:
                begin
                    st = ST_OK;
                end
            endcase
            result_next.status     = st;
            result_next.elem_value = '0;
            result_next.elem_index = '0;
            result_next.count      = 7'(count_next);
            result_next.last       = 1'b1;
        end

        if (cmd.trav_step)
        begin
            // rotate the valid cells so the head walks out one per beat
            for (int i = 0; i < LIST_CAP; i++)
            begin
                if (CW'(i) + CW'(1) < count_reg)
                begin
                    cells_next[i] = up[i];
                end
                else if (CW'(i) + CW'(1) == count_reg)
                begin
                    cells_next[i] = cells_reg[0];
                end
            end
            trav_idx_next          = trav_idx_reg + IW'(1);
            result_next.status     = ST_OK;
            result_next.elem_value = cells_reg[0];
            result_next.elem_index = 6'(trav_idx_reg);
            result_next.count      = cnt7;
            result_next.last       = stat.trav_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item;
        end
        cells_reg  <= cells_next;
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            trav_idx_reg <= '0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            trav_idx_reg <= trav_idx_next;
            valid_reg    <= cmd.exec | cmd.trav_step;
        end
    end

    assign result       = result_reg;
    assign result_valid = valid_reg;

endmodule

// ----- sv/positional_list_engine.sv -----
// Positional list engine: an ordered list of up to LIST_CAP signed 32-bit values.
// Command channel: drive item (action, position, value) with start; the beat is
// taken on a rising edge with start high and busy low. busy stays high while the
// beat is worked on.
// Result channel: each result beat is on result for one cycle, marked by
// result_valid; result.last marks the final beat of a command.
// The status beat of an edit, clear or empty traverse is registered from the
// execute state, and busy drops in the cycle that beat shows, so a new command
// can be taken only once the previous one has delivered its beat.
// Traverse of N elements: N beats on consecutive cycles, the first registered
// from the execute state; the next command can follow once the last beat shows.
// The list cells rotate by one place per beat and are back in order after the
// last beat. Insert and delete shift every cell behind the position at once.
// Reset clears the element count and the controller; cell contents are kept
// invalid by the count. The receiver cannot stall: every beat must be taken.
module positional_list_engine #(
    parameter int LIST_CAP = ple_pkg::LIST_CAP_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  ple_pkg::item_t   item,
    output ple_pkg::result_t result,
    output logic             result_valid
);
    import ple_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    ple_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    ple_dpath #(
        .LIST_CAP (LIST_CAP)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .stat         (stat),
        .result       (result),
        .result_valid (result_valid)
    );

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accepted command");

    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.last |=> !result_valid)
        else $error("result beat right after last beat");

    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status != ST_OK |-> result.last)
        else $error("error status on non-final beat");

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.count <= 7'(LIST_CAP))
        else $error("count above capacity");

endmodule

// ----- tb/sv/positional_list_engine_test.sv -----
module positional_list_engine_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ple_pkg::*;

    localparam int CAP          = LIST_CAP_DEF;
    localparam int STIM_ITEMS   = 420;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SHOWN_ERRORS = 20;

    localparam logic [2:0] ACT_SPARE6 = 3'd6;
    localparam logic [2:0] ACT_SPARE7 = 3'd7;

    logic    clk   = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    logic    busy;
    item_t   item  = '0;
    result_t result;
    logic    result_valid;

    positional_list_engine #(
        .LIST_CAP(CAP)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .item(item),
        .result(result),
        .result_valid(result_valid)
    );

    always #2 clk = ~clk;

    item_t              cmd_q[$];
    result_t            beat_q[$];
    logic signed [31:0] cells[CAP];
    int                 cell_n      = 0;
    int                 peak_n      = 0;
    int                 gen_n       = 0;
    int                 cmds_queued = 0;
    int                 cmds_taken  = 0;
    int                 beats_seen  = 0;
    int                 full_seen   = 0;
    int                 range_seen  = 0;
    int                 errors      = 0;
    int                 gap_left    = 0;
    bit                 no_idle     = 1'b0;
    int                 cycles      = 0;

    function automatic void push_beat(logic [1:0] st, logic signed [31:0] v, int idx, bit last);
        result_t r;
        r.status     = st;
        r.elem_value = v;
        r.elem_index = 6'(idx);
        r.count      = 7'(cell_n);
        r.last       = last;
        beat_q.push_back(r);
    endfunction

    function automatic logic [1:0] list_insert(int idx, logic signed [31:0] v);
        if (idx > cell_n)
            return ST_RANGE;
        if (cell_n >= CAP)
            return ST_FULL;
        for (int i = cell_n; i > idx; i--)
            cells[i] = cells[i - 1];
        cells[idx] = v;
        cell_n++;
        if (cell_n > peak_n)
            peak_n = cell_n;
        return ST_OK;
    endfunction

    function automatic void apply_cmd(item_t it);
        int         idx;
        logic [1:0] st;
        idx = (it.position == 0) ? 0 : int'(it.position) - 1;
        st  = ST_OK;
        case (it.action)
            ACT_INS_FRONT: st = list_insert(0, it.value);
            ACT_APPEND:    st = list_insert(cell_n, it.value);
            ACT_INS_POS:   st = list_insert(idx, it.value);
            ACT_DEL_POS:
            begin
                if (idx >= cell_n)
                    st = ST_RANGE;
                else
                begin
                    for (int i = idx; i + 1 < cell_n; i++)
                        cells[i] = cells[i + 1];
                    cell_n--;
                end
            end
            ACT_TRAVERSE:
            begin
                if (cell_n == 0)
                    st = ST_RANGE;
                else
                begin
                    for (int i = 0; i < cell_n; i++)
                        push_beat(ST_OK, cells[i], i, i + 1 == cell_n);
                    return;
                end
            end
            ACT_CLEAR: cell_n = 0;
            default: ;
        endcase
        push_beat(st, '0, 0, 1'b1);
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            if (errors <= SHOWN_ERRORS)
                $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
        end
    endfunction

    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_cmd(logic [2:0] act, int pos, logic signed [31:0] v);
        item_t it;
        int    idx;
        it.action   = act;
        it.position = 7'(pos);
        it.value    = v;
        cmd_q.push_back(it);
        cmds_queued++;
        idx = (pos == 0) ? 0 : pos - 1;
        case (act)
            ACT_INS_FRONT, ACT_APPEND: if (gen_n < CAP) gen_n++;
            ACT_INS_POS: if (idx <= gen_n && gen_n < CAP) gen_n++;
            ACT_DEL_POS: if (idx < gen_n) gen_n--;
            ACT_CLEAR:   gen_n = 0;
            default: ;
        endcase
    endtask

    task automatic queue_insert();
        case ($urandom_range(0, 2))
            0: queue_cmd(ACT_INS_FRONT, $urandom_range(0, 65), rand_value());
            1: queue_cmd(ACT_APPEND, $urandom_range(0, 65), rand_value());
            default: queue_cmd(ACT_INS_POS, $urandom_range(0, gen_n + 1), rand_value());
        endcase
    endtask

    task automatic queue_edit();
        if (gen_n == 0 || (gen_n < CAP && $urandom_range(0, 9) < 6))
            queue_insert();
        else
            queue_cmd(ACT_DEL_POS, $urandom_range(0, gen_n), rand_value());
    endtask

    always @(posedge clk or negedge rst_n)
    begin : drive_cmds
        logic go;
        if (!rst_n)
        begin
            start <= 1'b0;
            item  <= '0;
        end
        else
        begin
            go = start;
            if (start && !busy)
            begin
                apply_cmd(item);
                cmds_taken++;
                go = 1'b0;
                if ($urandom_range(0, 15) == 0)
                    no_idle = !no_idle;
                gap_left = no_idle ? 0 : $urandom_range(0, 5);
            end
            if (!go)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (cmd_q.size() > 0)
                begin
                    item <= cmd_q.pop_front();
                    go = 1'b1;
                end
            end
            start <= go;
        end
    end

    always @(posedge clk)
    begin : watch_results
        result_t want;
        if (rst_n && result_valid)
        begin
            beats_seen++;
            if (result.status == ST_FULL)
                full_seen++;
            if (result.status == ST_RANGE)
                range_seen++;
            if (beat_q.size() == 0)
            begin
                errors++;
                if (errors <= SHOWN_ERRORS)
                    $error("unexpected result beat: status %0d count %0d", result.status,
                           result.count);
            end
            else
            begin
                want = beat_q.pop_front();
                check_field("status", 32'(want.status), 32'(result.status));
                check_field("elem_value", want.elem_value, result.elem_value);
                check_field("elem_index", 32'(want.elem_index), 32'(result.elem_index));
                check_field("count", 32'(want.count), 32'(result.count));
                check_field("last", 32'(want.last), 32'(result.last));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        int n;

        // empty list corner cases
        queue_cmd(ACT_TRAVERSE, 0, 0);
        queue_cmd(ACT_DEL_POS, 1, 0);
        queue_cmd(ACT_DEL_POS, 0, 0);
        queue_cmd(ACT_INS_POS, 2, 32'h1234_5678);
        queue_cmd(ACT_SPARE6, 65, 32'hFFFF_FFFF);
        queue_cmd(ACT_SPARE7, 64, 32'h8000_0000);
        queue_cmd(ACT_CLEAR, 0, 0);

        queue_cmd(ACT_INS_FRONT, 0, 32'h7FFF_FFFF);
        queue_cmd(ACT_INS_FRONT, 65, 32'h8000_0000);
        queue_cmd(ACT_APPEND, 64, 32'h0000_0000);
        queue_cmd(ACT_INS_POS, 0, 32'hFFFF_FFFF);
        queue_cmd(ACT_INS_POS, 5, 32'h5A5A_5A5A);
        queue_cmd(ACT_INS_POS, 7, 32'h0000_0001);
        queue_cmd(ACT_INS_POS, 3, 32'hA5A5_A5A5);
        queue_cmd(ACT_TRAVERSE, 0, 0);
        queue_cmd(ACT_DEL_POS, 7, 0);
        queue_cmd(ACT_DEL_POS, 6, 0);
        queue_cmd(ACT_DEL_POS, 0, 0);
        queue_cmd(ACT_DEL_POS, 2, 0);
        queue_cmd(ACT_TRAVERSE, 65, 0);
        queue_cmd(ACT_CLEAR, 0, 0);
        queue_cmd(ACT_TRAVERSE, 0, 0);
        queue_cmd(ACT_DEL_POS, 1, 0);

        while (cmds_queued < STIM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    n = $urandom_range(4, 20);
                    repeat (n) queue_edit();
                    queue_cmd(ACT_TRAVERSE, $urandom_range(0, 65), rand_value());
                end
                4, 5:
                begin
                    while (gen_n < CAP)
                        queue_insert();
                    queue_cmd(ACT_APPEND, $urandom_range(0, 65), rand_value());
                    queue_cmd(ACT_INS_POS, gen_n + 1, rand_value());
                    queue_cmd(ACT_INS_POS, $urandom_range(gen_n + 2, 65), rand_value());
                    queue_cmd(ACT_INS_FRONT, $urandom_range(0, 65), rand_value());
                    queue_cmd(ACT_TRAVERSE, $urandom_range(0, 65), rand_value());
                    n = $urandom_range(1, CAP);
                    repeat (n) queue_cmd(ACT_DEL_POS, $urandom_range(0, gen_n), rand_value());
                    queue_cmd(ACT_TRAVERSE, $urandom_range(0, 65), rand_value());
                end
                6:
                begin
                    queue_cmd(ACT_CLEAR, $urandom_range(0, 65), rand_value());
                    queue_cmd(ACT_TRAVERSE, $urandom_range(0, 65), rand_value());
                    queue_cmd(ACT_DEL_POS, $urandom_range(0, 65), rand_value());
                end
                default:
                begin
                    n = $urandom_range(3, 8);
                    repeat (n) queue_cmd(3'($urandom_range(0, 7)), $urandom_range(0, 65),
                                         rand_value());
                end
            endcase
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (cmds_taken < cmds_queued) @(posedge clk);
        while (beat_q.size() != 0) @(posedge clk);
        repeat (CAP + 8) @(posedge clk);

        $display("Ran %0d commands with %0d result beats; list peaked at %0d of %0d entries.",
                 cmds_taken, beats_seen, peak_n, CAP);
        $display("Rejected beats seen: %0d full-list, %0d out-of-range or empty.",
                 full_seen, range_seen);
        if (errors == 0 && beat_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
